@@ hdl/double_ended_stack_allocator_assert.svh @@
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_ASSERT_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_ASSERT_SVH

// checked while out of reset
`define DSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define DSA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dsa_pkg.sv @@
package dsa_pkg;

  localparam int WORD_BYTES_DEF   = 8;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [3:0] OP_HIGH_PERM      = 4'd0;
  localparam logic [3:0] OP_LOW_PERM       = 4'd1;
  localparam logic [3:0] OP_TEMP_LOW       = 4'd2;
  localparam logic [3:0] OP_TEMP_HIGH      = 4'd3;
  localparam logic [3:0] OP_REALLOC        = 4'd4;
  localparam logic [3:0] OP_FREE           = 4'd5;
  localparam logic [3:0] OP_CONVERT        = 4'd6;
  localparam logic [3:0] OP_CLR_LOW_TEMP   = 4'd7;
  localparam logic [3:0] OP_CLR_HIGH_TEMP  = 4'd8;
  localparam logic [3:0] OP_CLR_HIGH       = 4'd9;
  localparam logic [3:0] OP_CLR_LOW        = 4'd10;
  localparam logic [3:0] OP_CLR_ALL        = 4'd11;
  localparam logic [3:0] OP_GET_MARK       = 4'd12;
  localparam logic [3:0] OP_HIDE           = 4'd13;
  localparam logic [3:0] OP_SHOW           = 4'd14;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [3:0]  op;
    logic [30:0] size;
    logic [3:0]  align_log2;
    logic [30:0] mark;
  } req_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [30:0] size;
    logic [30:0] mark;
    logic [31:0] align_mask;
    logic [31:0] size_plus_mask;
    logic [31:0] padded;
  } cmd_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] value;
    logic [1:0]  status;
    logic [31:0] low_perm_out;
    logic [31:0] low_temp_out;
    logic [31:0] high_perm_out;
    logic [31:0] high_temp_out;
  } rsp_t;

endpackage

@@ hdl/double_ended_stack_allocator.sv @@
// Two-ended bump allocator bookkeeping over one region.
// Request channel: in_valid / in_ready with an in_data word holding op, size,
// align_log2 and mark. Result channel: out_valid / out_ready with an out_data
// word holding address, value, status and the four marks after the request.
// Config channel: cfg_valid / cfg_ready writes region_total; cfg_ready is
// always high, and writes are meant for when no request is in flight.
// Path: a request accepted by the input stage moves on into the queue and then
// into the result register, which holds the result word.
// Throughput: one request per cycle while out_ready is high; every operation
// is resolved in the back stage, in which the mark registers read and update,
// and word rounding of sizes is done ahead of that in the input stage.
// Reset (rst, synchronous) clears all four marks, region_total and every
// valid bit; no request is held across it.
// When the receiver stalls, the result register holds its word, the queue
// between the input stage and the mark update fills, and in_ready drops
// once the queue and the input stage are both full; nothing is lost or repeated.
module double_ended_stack_allocator #(
  parameter int WORD_BYTES   = dsa_pkg::WORD_BYTES_DEF,
  parameter int HEADER_BYTES = dsa_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [30:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  dsa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dsa_pkg::rsp_t out_data
);

  logic          push_valid;
  logic          push_ready;
  dsa_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  dsa_pkg::cmd_t pop_cmd;

  assign cfg_ready = 1'b1;

  dsa_front #(
    .WORD_BYTES  (WORD_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  dsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  dsa_back #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_cmd  (pop_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ hdl/dsa_queue.sv @@
module dsa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  dsa_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dsa_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = dsa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsa_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/dsa_front.sv @@
module dsa_front #(
  parameter int WORD_BYTES   = dsa_pkg::WORD_BYTES_DEF,
  parameter int HEADER_BYTES = dsa_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dsa_pkg::req_t in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output dsa_pkg::cmd_t push_cmd
);

  localparam logic [31:0] WORD_U  = 32'(WORD_BYTES);
  localparam logic [31:0] HDR_U   = 32'(HEADER_BYTES);
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / WORD_BYTES);

  logic        a_valid;
  logic [3:0]  a_op;
  logic [30:0] a_size;
  logic [3:0]  a_align;
  logic [30:0] a_mark;
  logic [31:0] a_x;
  logic [31:0] a_q;

  logic [31:0] x;
  logic [63:0] product;
  logic [31:0] qw;
  logic [31:0] rem0;
  logic [31:0] rem;
  logic [31:0] align_mask;

  // word rounding: quotient estimate by reciprocal, off by at most one
  assign x       = 32'(in_data.size) + 32'(WORD_BYTES - 1);
  assign product = 64'(x) * 64'(RECIP);

  assign in_ready = !a_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_op    <= in_data.op;
      a_size  <= in_data.size;
      a_align <= in_data.align_log2;
      a_mark  <= in_data.mark;
      a_x     <= x;
      a_q     <= product[63:32];
    end
  end

  assign qw         = a_q * WORD_U;
  assign rem0       = a_x - qw;
  assign rem        = (rem0 >= WORD_U) ? rem0 - WORD_U : rem0;
  assign align_mask = (32'd1 << a_align) - 32'd1;

  assign push_valid              = a_valid;
  assign push_cmd.op             = a_op;
  assign push_cmd.size           = a_size;
  assign push_cmd.mark           = a_mark;
  assign push_cmd.align_mask     = align_mask;
  assign push_cmd.size_plus_mask = 32'(a_size) + align_mask;
  assign push_cmd.padded         = a_x - rem + HDR_U;

endmodule

@@ hdl/dsa_back.sv @@
module dsa_back #(
  parameter int HEADER_BYTES = dsa_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [30:0]   cfg_data,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  dsa_pkg::cmd_t pop_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output dsa_pkg::rsp_t out_data
);

  localparam logic [31:0] HDR_U = 32'(HEADER_BYTES);

  logic [30:0] region;
  logic [31:0] lp;
  logic [31:0] lt;
  logic [31:0] hp;
  logic [31:0] ht;

  logic [31:0] lp_next;
  logic [31:0] lt_next;
  logic [31:0] hp_next;
  logic [31:0] ht_next;
  logic [31:0] addr;
  logic [31:0] val;
  logic [1:0]  status;

  logic [31:0] region32;
  logic [31:0] size32;
  logic [31:0] mark32;
  logic [31:0] hp_al;
  logic [31:0] lp_al;
  logic [31:0] lp_alloc;
  logic [31:0] lt_temp;
  logic [31:0] ht_temp;
  logic [31:0] lt_realloc;
  logic        do_pop;

  function automatic logic exceeds(input logic [31:0] a, input logic [31:0] b,
                                   input logic [30:0] total);
    return ({1'b0, a} + {1'b0, b}) > {2'b0, total};
  endfunction

  assign region32   = {1'b0, region};
  assign size32     = {1'b0, pop_cmd.size};
  assign mark32     = {1'b0, pop_cmd.mark};
  assign hp_al      = (hp + pop_cmd.size_plus_mask) & ~pop_cmd.align_mask;
  assign lp_al      = (lp + pop_cmd.align_mask) & ~pop_cmd.align_mask;
  assign lp_alloc   = lp_al + size32;
  assign lt_temp    = lt + pop_cmd.padded;
  assign ht_temp    = ht + size32;
  assign lt_realloc = lp + size32;

  assign pop_ready = !out_valid || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    lp_next = lp;
    lt_next = lt;
    hp_next = hp;
    ht_next = ht;
    addr    = '0;
    val     = '0;
    status  = dsa_pkg::STATUS_OK;
    case (pop_cmd.op)
      dsa_pkg::OP_HIGH_PERM: begin
        hp_next = hp_al;
        ht_next = hp_al;
        addr    = region32 - hp_al;
        if (exceeds(lt, hp_al, region)) status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_LOW_PERM: begin
        addr    = lp_al;
        lp_next = lp_alloc;
        lt_next = lp_alloc;
        if (exceeds(lp_alloc, ht, region)) status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_TEMP_LOW: begin
        addr    = lt + HDR_U;
        lt_next = lt_temp;
        val     = pop_cmd.padded;
        if (exceeds(lt_temp, ht, region)) status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_TEMP_HIGH: begin
        ht_next = ht_temp;
        addr    = region32 - ht_temp;
        if (exceeds(lt, ht_temp, region)) status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_REALLOC: begin
        lt_next = lt_realloc;
        addr    = lp;
        if (exceeds(lt_realloc, ht, region)) status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_FREE: begin
        if (size32 > lt) begin
          lt_next = '0;
          status  = dsa_pkg::STATUS_UNDERFLOW;
        end else begin
          lt_next = lt - size32;
        end
      end
      dsa_pkg::OP_CONVERT: begin
        lp_next = lt;
      end
      dsa_pkg::OP_CLR_LOW_TEMP: begin
        lt_next = lp;
      end
      dsa_pkg::OP_CLR_HIGH_TEMP: begin
        ht_next = hp;
      end
      dsa_pkg::OP_CLR_HIGH: begin
        ht_next = mark32;
        hp_next = mark32;
      end
      dsa_pkg::OP_CLR_LOW: begin
        lt_next = mark32;
        lp_next = mark32;
      end
      dsa_pkg::OP_CLR_ALL: begin
        lp_next = '0;
        lt_next = '0;
        hp_next = '0;
        ht_next = '0;
      end
      dsa_pkg::OP_GET_MARK: begin
        val = hp;
      end
      dsa_pkg::OP_HIDE: begin
        val     = lp;
        lp_next = lt;
      end
      dsa_pkg::OP_SHOW: begin
        lp_next = mark32;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region    <= '0;
      lp        <= '0;
      lt        <= '0;
      hp        <= '0;
      ht        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        region <= cfg_data;
      end
      if (do_pop) begin
        lp        <= lp_next;
        lt        <= lt_next;
        hp        <= hp_next;
        ht        <= ht_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      out_data.address       <= addr;
      out_data.value         <= val;
      out_data.status        <= status;
      out_data.low_perm_out  <= lp_next;
      out_data.low_temp_out  <= lt_next;
      out_data.high_perm_out <= hp_next;
      out_data.high_temp_out <= ht_next;
    end
  end

endmodule

@@ hdl/dsa_checker.sv @@
`include "double_ended_stack_allocator_assert.svh"

module dsa_checker (
  input logic          clk,
  input logic          rst,
  input logic          cfg_valid,
  input logic          cfg_ready,
  input logic          out_valid,
  input logic          out_ready,
  input dsa_pkg::rsp_t out_data
);

  // stalled result word holds
  `DSA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data),
    "result word changed while stalled")

  // no result word right after reset
  `DSA_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // saturated free leaves the low temp mark at zero
  `DSA_ASSERT(a_underflow_zero,
    out_valid && out_data.status == dsa_pkg::STATUS_UNDERFLOW |-> out_data.low_temp_out == 32'd0,
    "underflow without zero low temp mark")

  // config port never stalls
  `DSA_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "config write stalled")

endmodule

bind double_ended_stack_allocator dsa_checker u_checker (.*);

@@ dv/double_ended_stack_allocator_tb.sv @@
module double_ended_stack_allocator_tb;

  localparam int WORD_BYTES   = dsa_pkg::WORD_BYTES_DEF;
  localparam int HEADER_BYTES = dsa_pkg::HEADER_BYTES_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam logic [3:0] OP_UNUSED = 4'd15;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  [30:0] cfg_data = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  dsa_pkg::req_t in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  dsa_pkg::rsp_t out_data;

  double_ended_stack_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // allocator bookkeeping as the testbench sees it
  logic [31:0] region_bytes = '0;
  logic [31:0] lo_perm = '0;
  logic [31:0] lo_temp = '0;
  logic [31:0] hi_perm = '0;
  logic [31:0] hi_temp = '0;

  dsa_pkg::rsp_t predicted_replies[$];
  dsa_pkg::rsp_t oldest_reply;
  dsa_pkg::rsp_t last_reply;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   gap_pending = 0;
  bit   input_held = 0;
  int   stall_left = 0;
  logic [8:0] stall_phase = '0;

  function automatic logic [31:0] round_up_pow2(logic [31:0] x, logic [31:0] a);
    return (x + a - 32'd1) & ~(a - 32'd1);
  endfunction

  function automatic bit overflows(logic [31:0] a, logic [31:0] b);
    return ({1'b0, a} + {1'b0, b}) > {1'b0, region_bytes};
  endfunction

  function automatic dsa_pkg::rsp_t apply_allocator_op(dsa_pkg::req_t r);
    dsa_pkg::rsp_t o;
    logic [31:0]   sz;
    logic [31:0]   mk;
    logic [31:0]   align;
    logic [31:0]   padded;
    logic [63:0]   rounded;
    sz    = {1'b0, r.size};
    mk    = {1'b0, r.mark};
    align = 32'd1 << r.align_log2;
    o     = '0;
    o.status = dsa_pkg::STATUS_OK;
    case (r.op)
      dsa_pkg::OP_HIGH_PERM: begin
        hi_perm = round_up_pow2(hi_perm + sz, align);
        o.address = region_bytes - hi_perm;
        hi_temp = hi_perm;
        if (overflows(lo_temp, hi_perm)) o.status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_LOW_PERM: begin
        lo_perm = round_up_pow2(lo_perm, align);
        o.address = lo_perm;
        lo_perm = lo_perm + sz;
        lo_temp = lo_perm;
        if (overflows(lo_perm, hi_temp)) o.status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_TEMP_LOW: begin
        rounded = ({32'd0, sz} + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES)
                  * 64'(WORD_BYTES);
        padded = rounded[31:0] + 32'(HEADER_BYTES);
        o.address = lo_temp + 32'(HEADER_BYTES);
        lo_temp = lo_temp + padded;
        o.value = padded;
        if (overflows(lo_temp, hi_temp)) o.status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_TEMP_HIGH: begin
        hi_temp = hi_temp + sz;
        o.address = region_bytes - hi_temp;
        if (overflows(lo_temp, hi_temp)) o.status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_REALLOC: begin
        lo_temp = lo_perm + sz;
        o.address = lo_perm;
        if (overflows(lo_temp, hi_temp)) o.status = dsa_pkg::STATUS_OVERFLOW;
      end
      dsa_pkg::OP_FREE: begin
        if (sz > lo_temp) begin
          lo_temp = '0;
          o.status = dsa_pkg::STATUS_UNDERFLOW;
        end else begin
          lo_temp = lo_temp - sz;
        end
      end
      dsa_pkg::OP_CONVERT:       lo_perm = lo_temp;
      dsa_pkg::OP_CLR_LOW_TEMP:  lo_temp = lo_perm;
      dsa_pkg::OP_CLR_HIGH_TEMP: hi_temp = hi_perm;
      dsa_pkg::OP_CLR_HIGH: begin
        hi_temp = mk;
        hi_perm = mk;
      end
      dsa_pkg::OP_CLR_LOW: begin
        lo_temp = mk;
        lo_perm = mk;
      end
      dsa_pkg::OP_CLR_ALL: begin
        lo_perm = '0;
        lo_temp = '0;
        hi_perm = '0;
        hi_temp = '0;
      end
      dsa_pkg::OP_GET_MARK: o.value = hi_perm;
      dsa_pkg::OP_HIDE: begin
        o.value = lo_perm;
        lo_perm = lo_temp;
      end
      dsa_pkg::OP_SHOW: lo_perm = mk;
      default: ;
    endcase
    o.low_perm_out  = lo_perm;
    o.low_temp_out  = lo_temp;
    o.high_perm_out = hi_perm;
    o.high_temp_out = hi_temp;
    return o;
  endfunction

  function automatic dsa_pkg::req_t make_req(logic [3:0] op, logic [30:0] size,
                                             logic [3:0] align_log2, logic [30:0] mark);
    dsa_pkg::req_t r;
    r.op         = op;
    r.size       = size;
    r.align_log2 = align_log2;
    r.mark       = mark;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // receiver: calm stretches alternate with random stalls
  always @(posedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    if (stall_phase[8]) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // results are sampled on the falling edge before the edge that takes them
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_replies.size() == 0) begin
        flag_mismatch("word with none expected", out_data.address, '0);
      end else begin
        oldest_reply = predicted_replies.pop_front();
        if (out_data.address !== oldest_reply.address)
          flag_mismatch("address", out_data.address, oldest_reply.address);
        if (out_data.value !== oldest_reply.value)
          flag_mismatch("value", out_data.value, oldest_reply.value);
        if (out_data.status !== oldest_reply.status)
          flag_mismatch("status", 32'(out_data.status), 32'(oldest_reply.status));
        if (out_data.low_perm_out !== oldest_reply.low_perm_out)
          flag_mismatch("low_perm_out", out_data.low_perm_out, oldest_reply.low_perm_out);
        if (out_data.low_temp_out !== oldest_reply.low_temp_out)
          flag_mismatch("low_temp_out", out_data.low_temp_out, oldest_reply.low_temp_out);
        if (out_data.high_perm_out !== oldest_reply.high_perm_out)
          flag_mismatch("high_perm_out", out_data.high_perm_out,
                        oldest_reply.high_perm_out);
        if (out_data.high_temp_out !== oldest_reply.high_temp_out)
          flag_mismatch("high_temp_out", out_data.high_temp_out,
                        oldest_reply.high_temp_out);
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input dsa_pkg::req_t r);
    bit took;
    repeat (gap_pending) @(posedge clk);
    gap_pending = 0;
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 12);
    in_valid   <= 1'b1;
    in_data    <= r;
    input_held = 1;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    last_reply = apply_allocator_op(r);
    predicted_replies.push_back(last_reply);
    burst_left--;
    if (burst_left == 0) begin
      in_valid   <= 1'b0;
      input_held = 0;
      gap_pending = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
    end
  endtask

  task automatic drain_requests();
    if (input_held) begin
      in_valid   <= 1'b0;
      input_held = 0;
    end
    burst_left  = 0;
    gap_pending = 0;
    wait (predicted_replies.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_region_total(input logic [30:0] total);
    bit took;
    drain_requests();
    cfg_valid <= 1'b1;
    cfg_data  <= total;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid    <= 1'b0;
    region_bytes = {1'b0, total};
  endtask

  // region left at its reset size of zero: the high permanent allocation overflows
  task automatic test_empty_region();
    send_request(make_req(dsa_pkg::OP_HIGH_PERM, 31'd5, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_GET_MARK, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_CLR_ALL, 31'd0, 4'd0, 31'd0));
  endtask

  task automatic test_directed_ops();
    write_region_total(31'd4096);
    send_request(make_req(dsa_pkg::OP_LOW_PERM, 31'd100, 4'd5, 31'd0));
    send_request(make_req(dsa_pkg::OP_LOW_PERM, 31'd0, 4'd15, 31'd0));
    send_request(make_req(dsa_pkg::OP_CLR_ALL, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_TEMP_LOW, 31'd1, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_TEMP_LOW, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_FREE, 31'd8, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_FREE, 31'h7FFF_FFFF, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_TEMP_HIGH, 31'd64, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_HIGH_PERM, 31'd10, 4'd12, 31'd0));
    send_request(make_req(dsa_pkg::OP_REALLOC, 31'h7FFF_FFFF, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_CONVERT, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_CLR_LOW_TEMP, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_CLR_HIGH_TEMP, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_GET_MARK, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_HIDE, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_SHOW, 31'd0, 4'd0, 31'h7FFF_FFFF));
    send_request(make_req(dsa_pkg::OP_CLR_HIGH, 31'd0, 4'd0, 31'h7FFF_FFFF));
    send_request(make_req(dsa_pkg::OP_CLR_LOW, 31'd0, 4'd0, 31'd0));
    send_request(make_req(OP_UNUSED, 31'h7FFF_FFFF, 4'd15, 31'h7FFF_FFFF));
    send_request(make_req(dsa_pkg::OP_CLR_ALL, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_TEMP_LOW, 31'h7FFF_FFFF, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_HIGH_PERM, 31'h7FFF_FFFF, 4'd15, 31'd0));
  endtask

  task automatic test_full_region();
    write_region_total(31'h7FFF_FFFF);
    send_request(make_req(dsa_pkg::OP_CLR_ALL, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_HIGH_PERM, 31'h7FFF_FFFF, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_LOW_PERM, 31'd1, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_TEMP_HIGH, 31'h7FFF_FFFF, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_CLR_ALL, 31'd0, 4'd0, 31'd0));
    send_request(make_req(dsa_pkg::OP_LOW_PERM, 31'h7FFF_FFFF, 4'd0, 31'd0));
  endtask

  task automatic test_random_traffic();
    logic [31:0]   padded_sizes[$];
    logic [31:0]   saved_high;
    logic [31:0]   saved_low;
    logic [31:0]   size_cap;
    logic [30:0]   region;
    dsa_pkg::req_t r;
    int unsigned   pick;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       region = 31'($urandom_range(256, 8192));
        1:       region = 31'($urandom());
        2:       region = 31'h7FFF_FFFF;
        default: region = 31'($urandom_range(64, 1024));
      endcase
      write_region_total(region);
      size_cap = ($urandom_range(0, 1) == 0) ? 32'd200 : ({1'b0, region} >> 3) + 32'd16;
      padded_sizes.delete();
      saved_high = '0;
      saved_low  = '0;
      repeat (235) begin
        // unused fields carry random content
        r.op         = OP_UNUSED;
        r.size       = 31'($urandom());
        r.align_log2 = 4'($urandom_range(0, 15));
        r.mark       = 31'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
          r.op   = dsa_pkg::OP_TEMP_LOW;
          r.size = 31'($urandom_range(0, size_cap));
        end else if (pick < 31) begin
          r.op   = dsa_pkg::OP_FREE;
          r.size = (padded_sizes.size() != 0) ? 31'(padded_sizes.pop_back())
                                              : 31'($urandom_range(0, size_cap));
        end else if (pick < 41) begin
          r.op         = dsa_pkg::OP_LOW_PERM;
          r.size       = 31'($urandom_range(0, size_cap));
          r.align_log2 = 4'($urandom_range(0, 12));
        end else if (pick < 51) begin
          r.op         = dsa_pkg::OP_HIGH_PERM;
          r.size       = 31'($urandom_range(0, size_cap));
          r.align_log2 = 4'($urandom_range(0, 12));
        end else if (pick < 58) begin
          r.op   = dsa_pkg::OP_TEMP_HIGH;
          r.size = 31'($urandom_range(0, size_cap));
        end else if (pick < 63) begin
          r.op   = dsa_pkg::OP_REALLOC;
          r.size = 31'($urandom_range(0, size_cap));
        end else if (pick < 67) begin
          r.op = dsa_pkg::OP_CONVERT;
        end else if (pick < 71) begin
          r.op = dsa_pkg::OP_CLR_LOW_TEMP;
        end else if (pick < 74) begin
          r.op = dsa_pkg::OP_CLR_HIGH_TEMP;
        end else if (pick < 77) begin
          r.op = dsa_pkg::OP_GET_MARK;
        end else if (pick < 80) begin
          r.op   = dsa_pkg::OP_CLR_HIGH;
          r.mark = 31'(saved_high);
        end else if (pick < 83) begin
          r.op = dsa_pkg::OP_HIDE;
        end else if (pick < 86) begin
          r.op   = dsa_pkg::OP_SHOW;
          r.mark = 31'(saved_low);
        end else if (pick < 88) begin
          r.op   = dsa_pkg::OP_CLR_LOW;
          r.mark = 31'($urandom_range(0, size_cap));
        end else if (pick < 89) begin
          r.op = dsa_pkg::OP_CLR_ALL;
        end else begin
          r.op = 4'($urandom_range(0, 15));
        end
        send_request(r);
        case (r.op)
          dsa_pkg::OP_TEMP_LOW: padded_sizes.push_back(last_reply.value);
          dsa_pkg::OP_GET_MARK: saved_high = last_reply.value;
          dsa_pkg::OP_HIDE:     saved_low = last_reply.value;
          dsa_pkg::OP_CLR_ALL, dsa_pkg::OP_CLR_LOW, dsa_pkg::OP_CLR_LOW_TEMP,
          dsa_pkg::OP_REALLOC: padded_sizes.delete();
          default: ;
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_region();
    test_directed_ops();
    test_full_region();
    test_random_traffic();
    drain_requests();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
